/* src/awm_pkg.sv */
// Shared constants and types for the anagram window matcher.
// No dependencies; imported by every module of the block.
package awm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int ALPHABET    = 26;

  localparam int SYM_W  = 5;                          // symbol field width
  localparam int NSLOT  = ALPHABET + 1;               // letters plus one foreign slot
  localparam int SLOT_W = $clog2(NSLOT);
  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);    // holds 0 .. MAX_PATTERN
  localparam int BAL_W  = $clog2(MAX_PATTERN + 1) + 1; // signed, +/- MAX_PATTERN
  localparam int NZ_W   = $clog2(NSLOT + 1);          // holds 0 .. NSLOT

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // update request to one letter cell
  typedef struct packed {
    logic clear;
    logic inc_hit;
    logic dec_hit;
  } awm_cell_cmd_t;

  // zero/nonzero transitions reported by one letter cell
  typedef struct packed {
    logic up_inc;
    logic down_inc;
    logic up_dec;
    logic down_dec;
  } awm_nz_flags_t;

  // one result transaction
  typedef struct packed {
    logic pattern_overflow;
    logic found_any;
    logic window_match;
  } awm_result_t;

endpackage

/* src/awm_letter_cell.sv */
// One letter balance counter of the anagram window matcher.
// Depends on awm_pkg for widths and the command/flag structs.
module awm_letter_cell
  import awm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          upd_en,
  input  awm_cell_cmd_t cmd,
  output awm_nz_flags_t flags
);

  logic signed [BAL_W-1:0] bal_r;
  logic signed [BAL_W-1:0] bal_nxt;
  logic signed [BAL_W-1:0] base;

  always_comb begin
    base  = cmd.clear ? '0 : bal_r;
    flags = '0;
    // a +1 and -1 on the same letter cancel: no transition
    if (cmd.inc_hit && !cmd.dec_hit) begin
      flags.up_inc   = (base == '0);
      flags.down_inc = (base == '1);
    end
    if (cmd.dec_hit && !cmd.inc_hit) begin
      flags.up_dec   = (base == '0);
      flags.down_dec = (base == BAL_W'(1));
    end
    bal_nxt = base + (cmd.inc_hit ? BAL_W'(1) : '0) - (cmd.dec_hit ? BAL_W'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bal_r <= '0;
    end else if (upd_en) begin
      bal_r <= bal_nxt;
    end
  end

endmodule

/* src/awm_window_cell.sv */
// One stage of the text window shift chain.
// Depends on awm_pkg for the symbol width.
module awm_window_cell
  import awm_pkg::*;
(
  input  logic             clk,
  input  logic             shift_en,
  input  logic [SYM_W-1:0] sym_in,
  output logic [SYM_W-1:0] sym_out
);

  logic [SYM_W-1:0] sym_r;

  // advance one place per accepted text symbol
  always_ff @(posedge clk) begin
    if (shift_en) begin
      sym_r <= sym_in;
    end
  end

  assign sym_out = sym_r;

endmodule

/* src/awm_out_buf.sv */
// Two-entry output buffer (holding register plus skid) for result transactions.
// Depends on awm_pkg for the result struct.
module awm_out_buf
  import awm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  awm_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_ready,
  output awm_result_t out_data
);

  logic        head_v_r, head_v_nxt;
  logic        skid_v_r, skid_v_nxt;
  awm_result_t head_r, head_nxt;
  awm_result_t skid_r, skid_nxt;
  logic        pop;

  assign pop = head_v_r && out_ready;

  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        head_nxt   = skid_r;
        head_v_nxt = 1'b1;
        skid_v_nxt = push;
        skid_nxt   = push_data;
      end else begin
        head_v_nxt = push;
        head_nxt   = push_data;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_nxt   = push_data;
        head_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = head_v_r;
  assign out_data  = head_r;

endmodule

/* src/anagram_window_matcher_top.sv */
// Anagram window matcher: one transaction per cycle unless the output buffer is full; each
// result is registered in the output buffer. The letter cell row sets that rate by taking
// the entering and leaving symbol updates together in the same cycle.
// Reset clears all letter balances and flags at once; no clearing pass is needed.
// The window shift chain is not reset; only symbols of the current query are read.
// Depends on awm_pkg, awm_letter_cell, awm_window_cell and awm_out_buf.
module anagram_window_matcher_top
  import awm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [4:0] symbol, [7:5] zero
  input  logic [0:0] in_tuser,   // [0] op
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] window_match, [1] found_any,
                                 // [2] pattern_overflow, [7:3] zero
);

  logic             in_acc;
  logic             is_text;
  logic [SYM_W-1:0] sym;
  logic [SLOT_W-1:0] enter_slot;
  logic [SLOT_W-1:0] leave_slot;
  logic [SYM_W-1:0]  leave_sym;

  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [LEN_W-1:0] tlen_r, tlen_nxt;
  logic [NZ_W-1:0]  nz_r, nz_nxt;
  logic             found_r, found_nxt;
  logic             ovf_r, ovf_nxt;
  logic             qopen_r, qopen_nxt;
  logic             tseen_r, tseen_nxt;

  logic             clr;
  logic [LEN_W-1:0] plen_base;
  logic [LEN_W-1:0] tlen_base;
  logic [NZ_W-1:0]  nz_base;
  logic             found_base;
  logic             ovf_base;
  logic             inc_en;
  logic             dec_en;
  logic [SLOT_W-1:0] inc_slot;
  logic             shift_en;
  logic             match;
  logic             push;
  logic             buf_full;

  awm_cell_cmd_t    cmd [NSLOT];
  awm_nz_flags_t    nzf [NSLOT];
  logic             up_i, down_i, up_d, down_d;

  logic [SYM_W-1:0] win [MAX_PATTERN];
  awm_result_t      res;
  awm_result_t      out_res;

  assign in_tready = !buf_full;
  assign in_acc    = in_tvalid && in_tready;
  assign is_text   = (in_tuser[0] == OP_TEXT);
  assign sym       = in_tdata[SYM_W-1:0];

  assign enter_slot = (32'(sym) < ALPHABET) ? SLOT_W'(sym) : SLOT_W'(ALPHABET);
  assign leave_slot = (32'(leave_sym) < ALPHABET) ? SLOT_W'(leave_sym) : SLOT_W'(ALPHABET);

  // leaving symbol always sits at window position 0
  assign leave_sym = win[0];

  // per-transaction control
  always_comb begin
    clr        = is_text ? !qopen_r : (!qopen_r || tseen_r);
    plen_base  = clr ? '0 : plen_r;
    tlen_base  = clr ? '0 : tlen_r;
    nz_base    = clr ? '0 : nz_r;
    found_base = clr ? 1'b0 : found_r;
    ovf_base   = clr ? 1'b0 : ovf_r;

    plen_nxt  = plen_base;
    tlen_nxt  = tlen_base;
    found_nxt = found_base;
    ovf_nxt   = ovf_base;
    tseen_nxt = clr ? 1'b0 : tseen_r;
    qopen_nxt = 1'b1;
    inc_en    = 1'b0;
    dec_en    = 1'b0;
    inc_slot  = enter_slot;
    shift_en  = 1'b0;
    match     = 1'b0;

    if (!is_text) begin
      if (32'(sym) < ALPHABET) begin
        if (plen_base < LEN_W'(MAX_PATTERN)) begin
          inc_en   = 1'b1;
          plen_nxt = plen_base + LEN_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end else begin
      tseen_nxt = 1'b1;
      if (ovf_base) begin
        match = 1'b0;
      end else if (plen_base == '0) begin
        match = 1'b1;
      end else begin
        inc_en   = (tlen_base >= plen_base);
        inc_slot = leave_slot;
        dec_en   = 1'b1;
        shift_en = 1'b1;
        if (tlen_base < plen_base) begin
          tlen_nxt = tlen_base + LEN_W'(1);
        end
        match = (nz_nxt == '0) && (tlen_nxt >= plen_base);
      end
      found_nxt = found_base || match;
      if (in_tlast) begin
        qopen_nxt = 1'b0;
      end
    end
  end

  // letter cell row
  for (genvar i = 0; i < NSLOT; i++) begin : g_letter
    assign cmd[i].clear   = clr;
    assign cmd[i].inc_hit = inc_en && (inc_slot == SLOT_W'(i));
    assign cmd[i].dec_hit = dec_en && (enter_slot == SLOT_W'(i));

    awm_letter_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .upd_en (in_acc),
      .cmd    (cmd[i]),
      .flags  (nzf[i])
    );
  end

  // each role hits at most one cell, so OR is enough
  always_comb begin
    up_i   = 1'b0;
    down_i = 1'b0;
    up_d   = 1'b0;
    down_d = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      up_i   = up_i   | nzf[i].up_inc;
      down_i = down_i | nzf[i].down_inc;
      up_d   = up_d   | nzf[i].up_dec;
      down_d = down_d | nzf[i].down_dec;
    end
    nz_nxt = nz_base + NZ_W'(up_i) + NZ_W'(up_d) - NZ_W'(down_i) - NZ_W'(down_d);
  end

  // window shift chain: the newest text symbol enters at position plen-1 and
  // advances toward position 0, which it reaches when it leaves the window
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_window
    if (k == MAX_PATTERN - 1) begin : g_tail
      awm_window_cell u_wcell (
        .clk      (clk),
        .shift_en (in_acc && shift_en),
        .sym_in   (sym),
        .sym_out  (win[k])
      );
    end else begin : g_body
      awm_window_cell u_wcell (
        .clk      (clk),
        .shift_en (in_acc && shift_en),
        .sym_in   ((plen_r == LEN_W'(k + 1)) ? sym : win[k+1]),
        .sym_out  (win[k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= '0;
      tlen_r  <= '0;
      nz_r    <= '0;
      found_r <= 1'b0;
      ovf_r   <= 1'b0;
      qopen_r <= 1'b0;
      tseen_r <= 1'b0;
    end else if (in_acc) begin
      plen_r  <= plen_nxt;
      tlen_r  <= tlen_nxt;
      nz_r    <= nz_nxt;
      found_r <= found_nxt;
      ovf_r   <= ovf_nxt;
      qopen_r <= qopen_nxt;
      tseen_r <= tseen_nxt;
    end
  end

  assign res.window_match     = match;
  assign res.found_any        = found_nxt;
  assign res.pattern_overflow = ovf_base;
  assign push                 = in_acc && is_text;

  awm_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {5'b0, out_res.pattern_overflow, out_res.found_any, out_res.window_match};

endmodule

/* tb/anagram_window_matcher_top_test.sv */
// Self-checking testbench for anagram_window_matcher_top: directed and random
// pattern/text queries, random stalls on both streams, results checked in order.
// Depends on awm_pkg and the matcher RTL.
module anagram_window_matcher_top_test;
  import awm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1800;
  localparam int STALL_LIMIT  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_GAP      = 4;

  typedef struct packed {
    logic             op;
    logic [SYM_W-1:0] sym;
    logic             last;
  } sym_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;   // [4:0] symbol, [7:5] zero
  logic [0:0] in_tuser = '0;   // [0] op
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;       // [0] window_match, [1] found_any, [2] pattern_overflow

  anagram_window_matcher_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  sym_item_t   symbol_queue[$];
  awm_result_t expected_verdicts[$];

  // predicted matcher state
  int               tally[NSLOT];
  int               nonzero_slots;
  logic [SYM_W-1:0] window_hist[MAX_PATTERN];
  int               pat_len;
  int               txt_len;
  int               ring_head;
  bit               seen_match;
  bit               pat_overflow;
  bit               query_live;
  bit               text_started;

  sym_item_t   on_bus;
  awm_result_t got_verdict;
  awm_result_t want_verdict;
  int          send_gap;
  int          recv_gap;
  bit          send_steady;
  bit          recv_steady;
  int          mismatches;
  int          idle_cycles;
  int          query_idx;
  int          base_items;

  function automatic void clear_tally();
    foreach (tally[i]) tally[i] = 0;
    nonzero_slots = 0;
    pat_len = 0;
    txt_len = 0;
    ring_head = 0;
    seen_match = 1'b0;
    pat_overflow = 1'b0;
    text_started = 1'b0;
    query_live = 1'b1;
  endfunction

  function automatic void nudge(int slot, int delta);
    int was;
    was = tally[slot];
    tally[slot] = was + delta;
    if (was == 0 && tally[slot] != 0) nonzero_slots++;
    else if (was != 0 && tally[slot] == 0) nonzero_slots--;
  endfunction

  function automatic void predict_symbol(sym_item_t it);
    int slot;
    int leave;
    int old;
    bit hit;
    awm_result_t r;
    slot = (it.sym < ALPHABET) ? int'(it.sym) : ALPHABET;
    hit = 1'b0;
    if (it.op == OP_PATTERN) begin
      if (!query_live || text_started) clear_tally();
      if (it.sym < ALPHABET) begin
        if (pat_len < MAX_PATTERN) begin
          nudge(slot, 1);
          pat_len++;
        end else begin
          pat_overflow = 1'b1;
        end
      end
    end else begin
      if (!query_live) clear_tally();
      text_started = 1'b1;
      if (pat_overflow) begin
        hit = 1'b0;
      end else if (pat_len == 0) begin
        hit = 1'b1;
      end else begin
        // return the symbol sliding out of the full window
        if (txt_len >= pat_len) begin
          leave = (ring_head >= pat_len) ? ring_head - pat_len
                                         : ring_head + MAX_PATTERN - pat_len;
          old = window_hist[leave];
          nudge((old < ALPHABET) ? old : ALPHABET, 1);
        end
        nudge(slot, -1);
        window_hist[ring_head] = it.sym;
        ring_head = (ring_head + 1 >= MAX_PATTERN) ? 0 : ring_head + 1;
        if (txt_len < pat_len) txt_len++;
        hit = (nonzero_slots == 0) && (txt_len >= pat_len);
      end
      if (hit) seen_match = 1'b1;
      r.window_match = hit;
      r.found_any = seen_match;
      r.pattern_overflow = pat_overflow;
      expected_verdicts.push_back(r);
      if (it.last) query_live = 1'b0;
    end
  endfunction

  task automatic add_item(logic op, int sym, logic last);
    sym_item_t it;
    it.op = op;
    it.sym = sym[SYM_W-1:0];
    it.last = last;
    symbol_queue.push_back(it);
  endtask

  function automatic int pick_letter(int base, int span, bit allow_foreign);
    if (allow_foreign && $urandom_range(0, 99) < 3) return $urandom_range(ALPHABET, 31);
    return base + $urandom_range(0, span - 1);
  endfunction

  // one query: a pattern, then text built mostly from shuffled copies of it
  task automatic add_query(bit force_overflow);
    int kind;
    int plen;
    int tlen;
    int span;
    int base;
    int n;
    int j;
    int t;
    int letters[$];
    int chunk[$];
    int text[$];
    kind = $urandom_range(0, 99);
    if (force_overflow || kind < 3) plen = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 6);
    else if (kind < 8) plen = 0;
    else if (kind < 16) plen = $urandom_range(7, MAX_PATTERN);
    else plen = $urandom_range(1, 6);
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, ALPHABET) : $urandom_range(1, 4);
    base = $urandom_range(0, ALPHABET - span);
    for (int i = 0; i < plen; i++) begin
      n = pick_letter(base, span, !force_overflow);
      if (n < ALPHABET) letters.push_back(n);
      add_item(OP_PATTERN, n, $urandom_range(0, 9) == 0);
    end
    if (plen > MAX_PATTERN) tlen = $urandom_range(1, 12);
    else tlen = $urandom_range(1, 2 * plen + 8);
    while (text.size() < tlen) begin
      if (letters.size() > 0 && $urandom_range(0, 99) < 60) begin
        chunk = letters;
        for (int i = chunk.size() - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = chunk[i];
          chunk[i] = chunk[j];
          chunk[j] = t;
        end
        foreach (chunk[i]) text.push_back(chunk[i]);
      end else begin
        text.push_back(pick_letter(base, span, 1'b1));
      end
    end
    // leave the query open now and then so the next pattern restarts it
    for (int i = 0; i < tlen; i++)
      add_item(OP_TEXT, text[i], (i == tlen - 1) && ($urandom_range(0, 4) != 0));
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_symbol(on_bus);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (symbol_queue.size() > 0) begin
          on_bus = symbol_queue.pop_front();
          in_tdata <= {3'b000, on_bus.sym};
          in_tuser <= on_bus.op;
          in_tlast <= on_bus.last;
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
          send_gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_verdict = awm_result_t'(out_tdata[2:0]);
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: match=%0b found=%0b ovf=%0b",
                     got_verdict.window_match, got_verdict.found_any,
                     got_verdict.pattern_overflow);
        end else begin
          want_verdict = expected_verdicts.pop_front();
          if (got_verdict.window_match !== want_verdict.window_match ||
              got_verdict.found_any !== want_verdict.found_any ||
              got_verdict.pattern_overflow !== want_verdict.pattern_overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected match=%0b found=%0b ovf=%0b, got %0b %0b %0b",
                       want_verdict.window_match, want_verdict.found_any,
                       want_verdict.pattern_overflow, got_verdict.window_match,
                       got_verdict.found_any, got_verdict.pattern_overflow);
          end
        end
        if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
        recv_gap = recv_steady ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: end the run if work is outstanding and nothing moves
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else if (symbol_queue.size() > 0 || in_tvalid || expected_verdicts.size() > 0) begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  initial begin
    clear_tally();
    query_live = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    send_gap = 0;
    recv_gap = 0;
    send_steady = 1'b0;
    recv_steady = 1'b0;

    // text with no query open runs against an empty pattern
    add_item(OP_TEXT, 0, 1'b0);
    add_item(OP_TEXT, 31, 1'b1);
    // last on a pattern symbol is ignored; foreign pattern symbol is dropped
    add_item(OP_PATTERN, 25, 1'b1);
    add_item(OP_PATTERN, 0, 1'b0);
    add_item(OP_PATTERN, 31, 1'b0);
    add_item(OP_TEXT, 0, 1'b0);
    add_item(OP_TEXT, 25, 1'b0);
    add_item(OP_TEXT, 30, 1'b0);
    add_item(OP_TEXT, 0, 1'b0);
    add_item(OP_TEXT, 25, 1'b1);
    // a pattern symbol after text of an open query restarts it
    add_item(OP_PATTERN, 1, 1'b0);
    add_item(OP_PATTERN, 1, 1'b0);
    add_item(OP_TEXT, 1, 1'b0);
    add_item(OP_TEXT, 1, 1'b0);
    add_item(OP_TEXT, 2, 1'b0);
    add_item(OP_PATTERN, 2, 1'b0);
    add_item(OP_TEXT, 3, 1'b0);
    add_item(OP_TEXT, 2, 1'b1);

    base_items = symbol_queue.size();
    query_idx = 0;
    while (symbol_queue.size() < base_items + RANDOM_ITEMS) begin
      add_query(query_idx == 3);
      query_idx++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (symbol_queue.size() > 0 || in_tvalid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
